/* hw/rtl/srtt_pkg.sv */
// srtt_pkg: shared types and constants of the session reverse tuple table
// no dependencies; used by the top level, srtt_apb and srtt_pipe

package srtt_pkg;

	// field widths
	localparam int SID_W    = 14;
	localparam int IP_W     = 32;
	localparam int PORT_W   = 16;
	localparam int IN_DW    = 80;   // session_id, remote_ip, local_port, remote_port + pad
	localparam int OUT_DW   = 112;  // adds out_local_ip + pad
	localparam int APB_AW   = 3;
	localparam int APB_DW   = 32;

	// command codes carried in s_tuser
	typedef enum logic [1:0] {
		CMD_INSERT  = 2'd0,
		CMD_RELEASE = 2'd1,
		CMD_LOOKUP  = 2'd2
	} cmd_t;

	// result kind carried in m_tuser
	localparam logic KIND_RELEASE = 1'b0;
	localparam logic KIND_REVERSE = 1'b1;

	// register index (paddr[2])
	localparam logic [0:0] REG_LOCAL_IP = 1'b0;

	// stored tuple: remote_ip 63..32, local_port 31..16, remote_port 15..0
	typedef struct packed {
		logic [IP_W-1:0]   remote_ip;
		logic [PORT_W-1:0] local_port;
		logic [PORT_W-1:0] remote_port;
	} tuple_t;

	localparam int TUPLE_W = $bits(tuple_t);

	// table write control from the lookup stage
	typedef struct packed {
		logic tuple_we;
		logic valid_we;
		logic valid_wdata;
	} wctl_t;

endpackage

/* hw/rtl/session_reverse_tuple_table.sv */
// session_reverse_tuple_table: per-session tuple store with insert, release and reverse lookup
// a result passes stage 1 and then the output register before it shows on m_tvalid
// throughput: one transaction per cycle unless stalled, set by one read/one write port per RAM
// reset: arst_n clears control state and local_ip; then a sweep over all SESSIONS entries
// zeroes the valid bits with s_tready held low; the tuple store itself is not cleared
// depends on srtt_pkg, srtt_ram, srtt_apb, srtt_clear, srtt_pipe

module session_reverse_tuple_table #(
	parameter int SESSIONS = 16384
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [srtt_pkg::APB_AW-1:0]  paddr,
	input  logic [srtt_pkg::APB_DW-1:0]  pwdata,
	output logic [srtt_pkg::APB_DW-1:0]  prdata,
	output logic                         pready,
	// commands
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [srtt_pkg::IN_DW-1:0]   s_tdata,  // session_id, remote_ip, local_port, remote_port
	input  logic [1:0]                   s_tuser,  // cmd
	// results
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [srtt_pkg::OUT_DW-1:0]  m_tdata,  // out_session_id, out_remote_ip,
	                                               // out_local_port, out_remote_port, out_local_ip
	output logic [0:0]                   m_tuser   // kind
);

	localparam int AW = $clog2(SESSIONS);

	logic [srtt_pkg::IP_W-1:0] local_ip;
	logic                      clr_busy;
	logic [AW-1:0]             clr_addr;
	logic                      rd_en;
	logic [AW-1:0]             rd_addr;
	srtt_pkg::tuple_t          rd_tuple;
	logic [0:0]                rd_valid;
	srtt_pkg::wctl_t           wctl;
	logic [AW-1:0]             wr_addr;
	srtt_pkg::tuple_t          wr_tuple;
	logic                      vb_we;
	logic [AW-1:0]             vb_waddr;
	logic [0:0]                vb_wdata;

	// configuration registers
	srtt_apb u_apb (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.local_ip (local_ip)
	);

	// valid bit sweep after reset
	srtt_clear #(.SESSIONS(SESSIONS)) u_clear (
		.clk    (clk),
		.arst_n (arst_n),
		.busy   (clr_busy),
		.addr   (clr_addr)
	);

	// command pipeline
	srtt_pipe #(.SESSIONS(SESSIONS)) u_pipe (
		.clk      (clk),
		.arst_n   (arst_n),
		.enable   (~clr_busy),
		.local_ip (local_ip),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_tuple (rd_tuple),
		.rd_valid (rd_valid[0]),
		.wctl     (wctl),
		.wr_addr  (wr_addr),
		.wr_tuple (wr_tuple)
	);

	// tuple store
	srtt_ram #(.WIDTH(srtt_pkg::TUPLE_W), .DEPTH(SESSIONS)) u_tuple_ram (
		.clk   (clk),
		.we    (wctl.tuple_we),
		.waddr (wr_addr),
		.wdata (wr_tuple),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_tuple)
	);

	// valid bits, shared write port between sweep and pipeline
	assign vb_we    = clr_busy | wctl.valid_we;
	assign vb_waddr = clr_busy ? clr_addr : wr_addr;
	assign vb_wdata = clr_busy ? 1'b0 : wctl.valid_wdata;

	srtt_ram #(.WIDTH(1), .DEPTH(SESSIONS)) u_valid_ram (
		.clk   (clk),
		.we    (vb_we),
		.waddr (vb_waddr),
		.wdata (vb_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_valid)
	);

`ifndef SYNTH
	// the pipeline never writes valid bits while the sweep owns the port
	a_no_write_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> !wctl.valid_we && !wctl.tuple_we)
		else $error("table write during valid sweep");

	// a tuple write always marks the entry valid
	a_insert_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		wctl.tuple_we |-> wctl.valid_we && wctl.valid_wdata)
		else $error("tuple written without valid bit set");

	// the sweep ends only after reaching the last entry
	a_sweep_complete: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clr_busy) |-> $past(clr_addr) == AW'(SESSIONS - 1))
		else $error("valid sweep ended early");
`endif

endmodule

/* hw/rtl/srtt_ram.sv */
// srtt_ram: generic single-write, single-read RAM with registered read data
// no dependencies

module srtt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hw/rtl/srtt_apb.sv */
// srtt_apb: APB register file holding the local IP address
// depends on srtt_pkg

module srtt_apb (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [srtt_pkg::APB_AW-1:0]  paddr,
	input  logic [srtt_pkg::APB_DW-1:0]  pwdata,
	output logic [srtt_pkg::APB_DW-1:0]  prdata,
	output logic                         pready,
	output logic [srtt_pkg::IP_W-1:0]    local_ip
);

	logic [srtt_pkg::IP_W-1:0] local_ip_q;
	logic [0:0]                reg_idx;
	logic                      wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[2];
	assign wr_en   = psel & penable & pwrite & pready;

	// register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_ip_q <= '0;
		end else if (wr_en && reg_idx == srtt_pkg::REG_LOCAL_IP) begin
			local_ip_q <= pwdata;
		end
	end

	// register read
	always_comb begin
		prdata = '0;
		if (reg_idx == srtt_pkg::REG_LOCAL_IP) begin
			prdata = local_ip_q;
		end
	end

	assign local_ip = local_ip_q;

endmodule

/* hw/rtl/srtt_clear.sv */
// srtt_clear: post-reset sweep that zeroes every valid bit, one entry per cycle
// no package dependency

module srtt_clear #(
	parameter int SESSIONS = 16384
) (
	input  logic                        clk,
	input  logic                        arst_n,
	output logic                        busy,
	output logic [$clog2(SESSIONS)-1:0] addr
);

	localparam int AW = $clog2(SESSIONS);

	logic          busy_q;
	logic [AW-1:0] cnt_q;

	// sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q == AW'(SESSIONS - 1)) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	assign busy = busy_q;
	assign addr = cnt_q;

endmodule

/* hw/rtl/srtt_pipe.sv */
// srtt_pipe: input handshake, table read stage with write forwarding, output register
// depends on srtt_pkg; drives the tuple and valid RAM ports of the top level

module srtt_pipe #(
	parameter int SESSIONS = 16384
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             enable,
	input  logic [srtt_pkg::IP_W-1:0]        local_ip,
	// input stream
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [srtt_pkg::IN_DW-1:0]       s_tdata,
	input  logic [1:0]                       s_tuser,
	// result stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [srtt_pkg::OUT_DW-1:0]      m_tdata,
	output logic [0:0]                       m_tuser,
	// table ports
	output logic                             rd_en,
	output logic [$clog2(SESSIONS)-1:0]      rd_addr,
	input  srtt_pkg::tuple_t                 rd_tuple,
	input  logic                             rd_valid,
	output srtt_pkg::wctl_t                  wctl,
	output logic [$clog2(SESSIONS)-1:0]      wr_addr,
	output srtt_pkg::tuple_t                 wr_tuple
);

	localparam int AW = $clog2(SESSIONS);
	localparam int XW = 17;  // holds any SESSIONS up to 65536

	// input field decode
	logic [srtt_pkg::SID_W-1:0] in_sid;
	srtt_pkg::tuple_t           in_tuple;
	srtt_pkg::cmd_t             in_cmd;
	logic [XW-1:0]              in_sid_x;
	logic                       in_range;
	logic                       accept;

	assign in_sid               = s_tdata[13:0];
	assign in_tuple.remote_ip   = s_tdata[45:14];
	assign in_tuple.local_port  = s_tdata[61:46];
	assign in_tuple.remote_port = s_tdata[77:62];
	assign in_cmd               = srtt_pkg::cmd_t'(s_tuser);
	assign in_sid_x             = XW'(in_sid);
	assign in_range             = in_sid_x < XW'(SESSIONS);

	// stage 1 registers
	logic                       vld_s1;
	srtt_pkg::cmd_t             cmd_s1;
	logic [srtt_pkg::SID_W-1:0] sid_s1;
	logic                       inr_s1;
	srtt_pkg::tuple_t           tuple_s1;
	logic                       fwd_tup_s1;
	logic                       fwd_vld_s1;
	srtt_pkg::tuple_t           fwd_tuple_s1;
	logic                       fwd_valid_s1;

	// output register
	logic                        m_tvalid_q;
	logic [srtt_pkg::OUT_DW-1:0] m_tdata_q;
	logic                        m_kind_q;

	// stage 1 evaluation
	srtt_pkg::tuple_t entry;
	logic             entry_valid;
	logic             res;
	logic             res_kind;
	logic             adv;
	logic             sid_match;

	always_comb begin
		entry       = fwd_tup_s1 ? fwd_tuple_s1 : rd_tuple;
		entry_valid = fwd_vld_s1 ? fwd_valid_s1 : rd_valid;
		if (!inr_s1) begin
			entry = '0;
		end
		res      = 1'b0;
		res_kind = srtt_pkg::KIND_RELEASE;
		case (cmd_s1)
			srtt_pkg::CMD_RELEASE: begin
				res = inr_s1 & entry_valid;
			end
			srtt_pkg::CMD_LOOKUP: begin
				res      = 1'b1;
				res_kind = srtt_pkg::KIND_REVERSE;
			end
			default: begin
				res = 1'b0;
			end
		endcase
	end

	assign adv      = ~res | ~m_tvalid_q | m_tready;
	assign s_tready = enable & (~vld_s1 | adv);
	assign accept   = s_tvalid & s_tready;

	// table writes leave stage 1 as the item moves on
	always_comb begin
		wctl          = '0;
		if (vld_s1 && adv && inr_s1) begin
			case (cmd_s1)
				srtt_pkg::CMD_INSERT: begin
					wctl.tuple_we    = 1'b1;
					wctl.valid_we    = 1'b1;
					wctl.valid_wdata = 1'b1;
				end
				srtt_pkg::CMD_RELEASE: begin
					wctl.valid_we    = 1'b1;
					wctl.valid_wdata = 1'b0;
				end
				default: begin
					wctl = '0;
				end
			endcase
		end
	end

	assign wr_addr  = XW'(sid_s1) < XW'(1 << AW) ? AW'(sid_s1) : '0;
	assign wr_tuple = tuple_s1;

	// table read issued with the accepted transaction
	assign rd_en     = accept;
	assign rd_addr   = in_sid_x[AW-1:0];
	assign sid_match = (sid_s1 == in_sid);

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	// stage 1 payload and forwarding of a same-cycle table write
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1       <= in_cmd;
			sid_s1       <= in_sid;
			inr_s1       <= in_range;
			tuple_s1     <= in_tuple;
			fwd_tup_s1   <= wctl.tuple_we & sid_match;
			fwd_vld_s1   <= wctl.valid_we & sid_match;
			fwd_tuple_s1 <= tuple_s1;
			fwd_valid_s1 <= wctl.valid_wdata;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (vld_s1 && adv && res) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (vld_s1 && adv && res) begin
			m_kind_q  <= res_kind;
			m_tdata_q <= {2'b00,
				(res_kind == srtt_pkg::KIND_REVERSE) ? local_ip : 32'd0,
				entry.remote_port, entry.local_port, entry.remote_ip, sid_s1};
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign m_tuser[0] = m_kind_q;

endmodule
